[src/lifeage_pkg.sv]
// Shared types and constants for the life automaton age step block.
package lifeage_pkg;

    localparam int AGE_W              = 7;
    localparam int CFG_DATA_W         = 11;
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;
    localparam int GRID_SIZE_RESET    = 64;

    localparam logic [AGE_W-1:0] AGE_MAX     = 7'd127;
    localparam logic [3:0]       BIRTH_COUNT = 4'd3;
    localparam logic [3:0]       SURVIVE_MIN = 4'd2;
    localparam logic [3:0]       SURVIVE_MAX = 4'd3;

    typedef enum logic
    {
        CMD_CELL  = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef enum logic
    {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        cmd_t             cmd;
        logic [AGE_W-1:0] cell_age;
    } cell_in_t;

    typedef struct packed
    {
        logic [AGE_W-1:0] new_age;
        logic             frame_last;
    } result_t;

endpackage

[src/life_automaton_age_step.sv]
// Top level of the life automaton age step: line store, 3x3 window and result queue.
//
// The block takes one cell transaction per clock while in_stall is low and gives each
// cell's next-generation age one row plus one cell later in raster order; the result of
// the transaction completing its neighbourhood passes the stage-one registers and the
// result queue. Both previous rows sit in a single line store of MAX_WIDTH words with a
// registered read, read at the cell's column as it is accepted and written back the
// following cycle. At the end of a frame, drain transactions each release one pending
// result; on a grid one row high the first drain reads the line store for the empty slot
// it skips and again for the slot that yields the result. A three-entry result queue lets
// the input run on while finished results wait. A configuration write restarts the frame.
module life_automaton_age_step
    import lifeage_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cell_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output result_t               out_data,
    input  logic                  cfg_wr_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WID_W        = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W        = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_W        = ROW_W + 1;
    localparam int MEM_W        = AGE_W + 1;
    localparam int FIFO_DEPTH   = 3;
    localparam int PTR_W        = 2;
    localparam int WIDTH_RESET  = (GRID_SIZE_RESET < MAX_WIDTH) ? GRID_SIZE_RESET : MAX_WIDTH;
    localparam int HEIGHT_RESET = (GRID_SIZE_RESET < MAX_HEIGHT) ? GRID_SIZE_RESET : MAX_HEIGHT;

    logic [WID_W-1:0] width_reg;
    logic [WID_W-1:0] width_next;
    logic [HGT_W-1:0] height_reg;
    logic [HGT_W-1:0] height_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             extra_reg;
    logic             extra_next;

    logic             in_accept;
    logic             is_cell;
    logic             frame_done;
    logic             issue_cell;
    logic             issue_drain;
    logic             issue;
    logic [COL_W-1:0] slot_col;
    logic [ROW_W-1:0] slot_row;
    logic [CMP_W-1:0] slot_row_ext;
    logic [CMP_W-1:0] h_ext;
    logic             slot_col_nz;
    logic             slot_top_en;
    logic             slot_mid_en;
    logic             slot_res_valid;
    logic             slot_last;
    logic [WID_W-1:0] col_plus;

    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    logic [MEM_W-1:0] mem_q_reg;
    logic             fwd_reg;
    logic [MEM_W-1:0] fwd_data_reg;

    logic             s1_valid_reg;
    logic             s1_real_reg;
    logic [AGE_W-1:0] s1_age_reg;
    logic             s1_top_en_reg;
    logic             s1_mid_en_reg;
    logic             s1_col_nz_reg;
    logic             s1_res_valid_reg;
    logic             s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;

    logic [8:0]       window_reg;
    logic [8:0]       window_next;
    logic [AGE_W-1:0] held_reg;
    logic [AGE_W-1:0] held_next;
    logic [MEM_W-1:0] rd_word;
    logic [AGE_W-1:0] mid_age;
    logic             mid_alive;
    logic             top_alive;
    logic             bot_alive;
    logic [2:0]       new_column;
    logic [8:0]       eval_bits;
    logic [3:0]       neighbours;
    logic [AGE_W-1:0] age_result;
    logic             mem_wr;
    logic [MEM_W-1:0] mem_wr_data;

    result_t          out_q [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] count_reg;
    logic             push;
    logic             pop;

    // Issue stage: position, slot flags and the line store read.
    assign in_accept  = in_valid && !in_stall;
    assign is_cell    = (in_data.cmd == CMD_CELL);
    assign h_ext      = CMP_W'(height_reg);
    assign frame_done = CMP_W'(row_reg) >= h_ext;

    assign issue_cell  = in_accept && is_cell;
    assign issue_drain = (in_accept && !is_cell && frame_done) || extra_reg;
    assign issue       = issue_cell || issue_drain;

    assign slot_col     = (issue_cell && frame_done) ? '0 : col_reg;
    assign slot_row     = (issue_cell && frame_done) ? '0 : row_reg;
    assign slot_row_ext = CMP_W'(slot_row);

    assign slot_col_nz    = (slot_col != '0);
    assign slot_top_en    = (slot_row_ext >= CMP_W'(2)) && (slot_row_ext <= h_ext + CMP_W'(1));
    assign slot_mid_en    = (slot_row_ext >= CMP_W'(1)) && (slot_row_ext <= h_ext);
    assign slot_res_valid = slot_col_nz ? slot_mid_en : slot_top_en;
    assign slot_last      = !slot_col_nz && (slot_row_ext == h_ext + CMP_W'(1));
    assign col_plus       = WID_W'(slot_col) + WID_W'(1);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        extra_next  = issue_drain && !extra_reg && !slot_res_valid;
        if (cfg_wr_en)
        begin
            col_next = '0;
            row_next = '0;
            unique case (cfg_index)
                CFG_GRID_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_next = WID_W'(1);
                    else if (int'(cfg_data) > MAX_WIDTH)
                        width_next = WID_W'(MAX_WIDTH);
                    else
                        width_next = WID_W'(cfg_data);
                end
                CFG_GRID_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_next = HGT_W'(1);
                    else if (int'(cfg_data) > MAX_HEIGHT)
                        height_next = HGT_W'(MAX_HEIGHT);
                    else
                        height_next = HGT_W'(cfg_data);
                end
            endcase
        end
        else if (issue)
        begin
            if (slot_last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_plus == width_reg)
            begin
                col_next = '0;
                row_next = slot_row + ROW_W'(1);
            end
            else
            begin
                col_next = slot_col + COL_W'(1);
                row_next = slot_row;
            end
        end
    end

    assign in_stall = extra_reg
                   || ((3'(count_reg) + 3'(s1_valid_reg)) > 3'(FIFO_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WID_W'(WIDTH_RESET);
            height_reg   <= HGT_W'(HEIGHT_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            extra_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            extra_reg    <= extra_next;
            s1_valid_reg <= issue;
            fwd_reg      <= issue && mem_wr && (s1_col_reg == slot_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_real_reg      <= issue_cell;
            s1_age_reg       <= in_data.cell_age;
            s1_top_en_reg    <= slot_top_en;
            s1_mid_en_reg    <= slot_mid_en;
            s1_col_nz_reg    <= slot_col_nz;
            s1_res_valid_reg <= slot_res_valid;
            s1_last_reg      <= slot_last;
            s1_col_reg       <= slot_col;
        end
        fwd_data_reg <= mem_wr_data;
    end

    // Line store: upper row alive bit above the age of the middle row.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            line_mem[s1_col_reg] <= mem_wr_data;
        if (issue)
            mem_q_reg <= line_mem[slot_col];
    end

    // Update stage: window shift, neighbour count and write-back.
    assign rd_word    = fwd_reg ? fwd_data_reg : mem_q_reg;
    assign mid_age    = s1_mid_en_reg ? rd_word[AGE_W-1:0] : '0;
    assign mid_alive  = (mid_age != '0);
    assign top_alive  = s1_top_en_reg && rd_word[MEM_W-1];
    assign bot_alive  = s1_real_reg && (s1_age_reg != '0);
    assign new_column = {bot_alive, mid_alive, top_alive};
    assign eval_bits  = s1_col_nz_reg ? {new_column, window_reg[8:3]}
                                      : {3'b000, window_reg[8:3]};

    assign window_next = s1_col_nz_reg ? eval_bits : {new_column, 6'b000000};
    assign held_next   = mid_age;
    assign mem_wr      = s1_valid_reg && s1_real_reg;
    assign mem_wr_data = {mid_alive, s1_age_reg};

    always_comb
    begin
        neighbours = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
                neighbours = neighbours + 4'(eval_bits[i]);
        end
    end

    always_comb
    begin
        age_result = '0;
        if (held_reg != '0)
        begin
            if (neighbours == SURVIVE_MIN || neighbours == SURVIVE_MAX)
                age_result = (held_reg == AGE_MAX) ? AGE_MAX : held_reg + AGE_W'(1);
        end
        else if (neighbours == BIRTH_COUNT)
        begin
            age_result = AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            held_reg   <= '0;
        end
        else if (s1_valid_reg)
        begin
            window_reg <= window_next;
            held_reg   <= held_next;
        end
    end

    // Result queue.
    assign push      = s1_valid_reg && s1_res_valid_reg;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = out_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_q[wr_ptr_reg].new_age    <= age_result;
            out_q[wr_ptr_reg].frame_last <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + PTR_W'(push) - PTR_W'(pop);
        end
    end

endmodule

[src/lifeage_checker.sv]
// Port-level assertions for the life automaton age step, bound to the top level.
module lifeage_checker
    import lifeage_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_stall,
    input logic    out_valid,
    input logic    out_stall,
    input result_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled result transaction changed or was withdrawn.");

    // A result can only appear after an accepted input transaction.
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2)
                          || $past(in_valid && !in_stall, 3))
        else $error("Result appeared without a matching input transaction.");

    // With no result waiting, the input is only held off just after a transaction.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid && !in_stall) |-> !in_stall)
        else $error("Input stalled while the block was idle.");

endmodule

bind life_automaton_age_step lifeage_checker u_lifeage_checker (.*);
